### sv/panel_reply_packet_checker_macros.svh
// Assertion macros for the panel reply packet checker.
// Used by panel_reply_packet_checker.sv; expects a clock named clk and a reset named rst.
`ifndef PANEL_REPLY_PACKET_CHECKER_MACROS_SVH
`define PANEL_REPLY_PACKET_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define PRC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("panel reply checker assertion failed");
// Checked on every clock edge, also in reset.
`define PRC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("panel reply checker assertion failed");
`else
`define PRC_ASSERT(label, prop)
`define PRC_ASSERT_ALWAYS(label, prop)
`endif
`endif

### sv/prc_pkg.sv
// Types, codes and helpers for the panel reply packet checker.
// No dependencies.
`timescale 1ns / 1ps

package prc_pkg;

  localparam logic [7:0] START_BYTE  = 8'h02;
  localparam logic [7:0] END_BYTE    = 8'h03;
  localparam logic [7:0] FLETCHER_MOD = 8'd255;
  localparam logic [3:0] BASE_LENGTH = 4'd6;
  localparam int         VALUE_SLOTS = 4;

  localparam logic [1:0] CFG_HAS_CHOICE  = 2'd0;
  localparam logic [1:0] CFG_HAS_ASSIGN  = 2'd1;
  localparam logic [1:0] CFG_KNOB_COUNT  = 2'd2;
  localparam logic [1:0] CFG_KNOB_BUTTON = 2'd3;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_BAD_START = 3'd2,
    ERR_CHECKSUM  = 3'd3,
    ERR_BAD_END   = 3'd4,
    ERR_BUTTONS   = 3'd5,
    ERR_ANALOG    = 3'd6
  } error_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_transfer;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  error_code;
    logic [7:0]  buttons;
    logic [7:0]  changed_mask;
    logic [31:0] analog_values;
  } out_item_t;

  // a + b mod 255, both operands already below 255 (b may be 255 raw)
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, FLETCHER_MOD}) begin
      s = s - {1'b0, FLETCHER_MOD};
    end
    return s[7:0];
  endfunction

endpackage

### sv/panel_reply_packet_checker.sv
// Panel reply packet checker: one input register, per-byte check logic, result register.
// Depends on prc_pkg and panel_reply_packet_checker_macros.svh.
// Path: an accepted byte is held in the input register and checked from there; its verdict
// (if any) is written into the result register, which holds out_valid high until it is taken.
// Throughput: one byte per cycle; only a held result blocks the single check stage.
// Reset (rst, synchronous): config registers and all per-transfer state cleared,
// both pipeline registers empty.
`timescale 1ns / 1ps
`include "panel_reply_packet_checker_macros.svh"

module panel_reply_packet_checker #(
  parameter int KNOB_SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  prc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prc_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);

  localparam logic [2:0] SLOT_LIMIT = 3'(KNOB_SLOTS);

  // configuration
  logic       has_choice;
  logic       has_assign;
  logic [2:0] knob_count;
  logic [3:0] knob_button_mask;

  // input register
  logic                s1_valid;
  prc_pkg::in_item_t   s1_data;
  logic                proc;

  // transfer state
  logic [3:0]  byte_position, byte_position_next;
  logic [3:0]  expected_length, expected_length_next;
  logic [7:0]  button_reg, button_reg_next;
  logic [7:0]  changed_mask_reg, changed_mask_reg_next;
  logic [7:0]  remaining_mask, remaining_mask_next;
  logic [31:0] value_store, value_store_next;
  logic [7:0]  sum_low, sum_high, sum_low_next, sum_high_next;
  logic [7:0]  received_check_high, received_check_high_next;
  logic        check_failed, check_failed_next;
  logic        verdict_given, verdict_given_next;

  logic              produce;
  prc_pkg::error_t   code;
  prc_pkg::out_item_t result;

  logic [2:0] kc;
  logic       buttons_ok;
  logic       analog_ok;
  logic [7:0] analog_allowed_mask;
  logic [3:0] bit_count;
  logic [2:0] low_bit;
  logic [4:0] pos_ext, len_ext;
  logic [7:0] b;
  logic       last;

  assign proc     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || proc;
  assign b        = s1_data.rx_byte;
  assign last     = s1_data.end_of_transfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_choice       <= 1'b0;
      has_assign       <= 1'b0;
      knob_count       <= 3'd0;
      knob_button_mask <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prc_pkg::CFG_HAS_CHOICE:  has_choice       <= cfg_data[0];
        prc_pkg::CFG_HAS_ASSIGN:  has_assign       <= cfg_data[0];
        prc_pkg::CFG_KNOB_COUNT:  knob_count       <= cfg_data[2:0];
        prc_pkg::CFG_KNOB_BUTTON: knob_button_mask <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // config-derived checks
  always_comb begin
    kc = (knob_count > SLOT_LIMIT) ? SLOT_LIMIT : knob_count;
    buttons_ok = !((button_reg[0] && !has_choice) || (button_reg[1] && !has_assign));
    for (int i = 0; i < KNOB_SLOTS; i++) begin
      if (3'(i) >= kc && button_reg[i + 2]) begin
        buttons_ok = 1'b0;
      end
    end
    analog_allowed_mask = 8'd0;
    for (int i = 0; i < prc_pkg::VALUE_SLOTS; i++) begin
      analog_allowed_mask[i] = (3'(i) < kc) && knob_button_mask[i];
    end
    analog_ok = (changed_mask_reg & ~analog_allowed_mask) == 8'd0;
  end

  // popcount of the incoming byte and lowest pending analog bit
  always_comb begin
    bit_count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      bit_count = bit_count + {3'd0, b[i]};
    end
    low_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (remaining_mask[i]) begin
        low_bit = 3'(i);
      end
    end
  end

  always_comb begin
    byte_position_next       = byte_position;
    expected_length_next     = expected_length;
    button_reg_next          = button_reg;
    changed_mask_reg_next    = changed_mask_reg;
    remaining_mask_next      = remaining_mask;
    value_store_next         = value_store;
    sum_low_next             = sum_low;
    sum_high_next            = sum_high;
    received_check_high_next = received_check_high;
    check_failed_next        = check_failed;
    verdict_given_next       = verdict_given;
    produce                  = 1'b0;
    code                     = prc_pkg::ERR_OK;
    pos_ext                  = {1'b0, byte_position};
    len_ext                  = {1'b0, expected_length};

    if (proc && !verdict_given) begin
      priority if (byte_position == 4'd0) begin
        if (b != prc_pkg::START_BYTE) begin
          produce = 1'b1;
          code    = prc_pkg::ERR_BAD_START;
        end
      end else if (byte_position == 4'd1) begin
        button_reg_next = b;
        sum_low_next    = prc_pkg::add_mod255(sum_low, b);
        sum_high_next   = prc_pkg::add_mod255(sum_high, sum_low_next);
      end else if (byte_position == 4'd2) begin
        changed_mask_reg_next = b;
        remaining_mask_next   = b;
        expected_length_next  = prc_pkg::BASE_LENGTH + bit_count;
        sum_low_next          = prc_pkg::add_mod255(sum_low, b);
        sum_high_next         = prc_pkg::add_mod255(sum_high, sum_low_next);
      end else if (pos_ext + 5'd3 < len_ext) begin
        // value byte belongs to the lowest analog bit not yet served
        remaining_mask_next[low_bit] = 1'b0;
        for (int j = 0; j < prc_pkg::VALUE_SLOTS; j++) begin
          if (j < KNOB_SLOTS && low_bit == 3'(j)) begin
            value_store_next[8*j +: 8] = b;
          end
        end
        sum_low_next  = prc_pkg::add_mod255(sum_low, b);
        sum_high_next = prc_pkg::add_mod255(sum_high, sum_low_next);
      end else if (pos_ext + 5'd3 == len_ext) begin
        received_check_high_next = b;
      end else if (pos_ext + 5'd2 == len_ext) begin
        check_failed_next = (received_check_high != sum_high) || (b != sum_low);
      end else begin
        produce = 1'b1;
        priority if (check_failed) begin
          code = prc_pkg::ERR_CHECKSUM;
        end else if (b != prc_pkg::END_BYTE) begin
          code = prc_pkg::ERR_BAD_END;
        end else if (!buttons_ok) begin
          code = prc_pkg::ERR_BUTTONS;
        end else if (!analog_ok) begin
          code = prc_pkg::ERR_ANALOG;
        end else begin
          code = prc_pkg::ERR_OK;
        end
      end

      if (!produce && last) begin
        produce = 1'b1;
        code    = prc_pkg::ERR_SHORT;
      end
      if (produce) begin
        verdict_given_next = 1'b1;
      end
      if (byte_position != 4'd15) begin
        byte_position_next = byte_position + 4'd1;
      end
    end

    if (proc && last) begin
      byte_position_next       = 4'd0;
      expected_length_next     = prc_pkg::BASE_LENGTH;
      button_reg_next          = 8'd0;
      changed_mask_reg_next    = 8'd0;
      remaining_mask_next      = 8'd0;
      value_store_next         = 32'd0;
      sum_low_next             = 8'd0;
      sum_high_next            = 8'd0;
      received_check_high_next = 8'd0;
      check_failed_next        = 1'b0;
      verdict_given_next       = 1'b0;
    end

    result.ok            = (code == prc_pkg::ERR_OK);
    result.error_code    = code;
    result.buttons       = result.ok ? button_reg : 8'd0;
    result.changed_mask  = result.ok ? changed_mask_reg : 8'd0;
    result.analog_values = result.ok ? value_store : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= 4'd0;
      expected_length     <= prc_pkg::BASE_LENGTH;
      button_reg          <= 8'd0;
      changed_mask_reg    <= 8'd0;
      remaining_mask      <= 8'd0;
      value_store         <= 32'd0;
      sum_low             <= 8'd0;
      sum_high            <= 8'd0;
      received_check_high <= 8'd0;
      check_failed        <= 1'b0;
      verdict_given       <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      byte_position       <= byte_position_next;
      expected_length     <= expected_length_next;
      button_reg          <= button_reg_next;
      changed_mask_reg    <= changed_mask_reg_next;
      remaining_mask      <= remaining_mask_next;
      value_store         <= value_store_next;
      sum_low             <= sum_low_next;
      sum_high            <= sum_high_next;
      received_check_high <= received_check_high_next;
      check_failed        <= check_failed_next;
      verdict_given       <= verdict_given_next;
      if (proc && produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (proc && produce) begin
      out_data <= result;
    end
  end

  `PRC_ASSERT(a_last_clears, proc && last |=> byte_position == 4'd0 && !verdict_given)
  `PRC_ASSERT(a_verdict_held, proc && produce && !last |=> verdict_given)
  `PRC_ASSERT(a_stall_cause, !in_ready |-> s1_valid && out_valid && !out_ready)

endmodule

### test/panel_reply_packet_checker_tb.sv
// Self-checking testbench for panel_reply_packet_checker: framed reply bytes in, verdicts out.
// Depends on prc_pkg and the checker RTL; verdicts are typed in directed rows, else predicted.
`timescale 1ns / 1ps

module panel_reply_packet_checker_tb;
  import prc_pkg::*;

  localparam int KNOB_SLOTS  = 4;
  localparam int ITEM_TARGET = 1150;
  localparam int NUM_PHASES  = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 4;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t verdict;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  // predictor copy of the configuration
  logic       p_choice, p_assign;
  logic [2:0] p_knobs;
  logic [3:0] p_kbmask;

  // predictor copy of the per-transfer state
  int          pos_cnt, frame_len, fl_lo, fl_hi;
  logic [7:0]  btn_seen, amask_seen, chk_hi_seen;
  logic [31:0] knob_vals;
  bit          chk_bad, done_flag;

  out_item_t pending_verdicts[$];
  in_item_t  frame_q[$];
  dir_row_t  dir_rows[$];

  int  mismatch_total = 0;
  int  bytes_sent = 0;
  int  transfers_sent = 0;
  int  configs_used = 0;
  int  code_hits[7];
  int  burst_left = 0;
  bit  steady = 0;
  bit  hold_pending = 0;

  panel_reply_packet_checker #(.KNOB_SLOTS(KNOB_SLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatch_total++;
    if (mismatch_total <= 40) begin
      $display("%0t  mismatch, %s: got %0h, wanted %0h", $time, what, got, want);
    end
  endtask

  function automatic int fletcher_add(int acc, int b);
    int s;
    s = acc + b;
    if (s >= int'(FLETCHER_MOD)) begin
      s = s - int'(FLETCHER_MOD);
    end
    return s;
  endfunction

  function automatic int knobs_clamped();
    return (int'(p_knobs) > KNOB_SLOTS) ? KNOB_SLOTS : int'(p_knobs);
  endfunction

  function automatic bit buttons_ok(logic [7:0] m);
    if (m[0] && !p_choice) return 0;
    if (m[1] && !p_assign) return 0;
    for (int i = knobs_clamped(); i < KNOB_SLOTS; i++) begin
      if (m[i + 2]) return 0;
    end
    return 1;
  endfunction

  function automatic bit analog_ok(logic [7:0] m);
    int kc;
    kc = knobs_clamped();
    for (int i = 0; i < 8; i++) begin
      if (m[i] && (i >= kc || i >= 4 || !p_kbmask[i])) return 0;
    end
    return 1;
  endfunction

  // knob index behind the n-th value byte, 8 when the mask runs out
  function automatic int nth_knob(logic [7:0] m, int n);
    for (int i = 0; i < 8; i++) begin
      if (m[i]) begin
        if (n == 0) return i;
        n--;
      end
    end
    return 8;
  endfunction

  function automatic logic [7:0] allowed_buttons();
    logic [7:0] m;
    m = 8'hC0;
    m[0] = p_choice;
    m[1] = p_assign;
    for (int i = 0; i < knobs_clamped(); i++) m[i + 2] = 1'b1;
    return m;
  endfunction

  function automatic logic [7:0] allowed_analog();
    logic [7:0] m;
    m = 8'h00;
    for (int i = 0; i < knobs_clamped() && i < 4; i++) m[i] = p_kbmask[i];
    return m;
  endfunction

  task automatic clear_frame();
    pos_cnt     = 0;
    frame_len   = int'(BASE_LENGTH);
    btn_seen    = '0;
    amask_seen  = '0;
    knob_vals   = '0;
    fl_lo       = 0;
    fl_hi       = 0;
    chk_hi_seen = '0;
    chk_bad     = 0;
    done_flag   = 0;
  endtask

  // advance the predictor by one accepted byte; got says whether a verdict falls due
  task automatic track_byte(input in_item_t it, output bit got, output out_item_t res);
    logic [7:0] b;
    error_t     code;
    bit         decided;
    int         k;
    b       = it.rx_byte;
    got     = 0;
    res     = '0;
    decided = 0;
    code    = ERR_OK;
    if (done_flag) begin
      if (it.end_of_transfer) clear_frame();
      return;
    end
    if (pos_cnt == 0) begin
      if (b != START_BYTE) begin
        code = ERR_BAD_START;
        decided = 1;
      end
    end else if (pos_cnt == 1) begin
      btn_seen = b;
      fl_lo = fletcher_add(fl_lo, b);
      fl_hi = fletcher_add(fl_hi, fl_lo);
    end else if (pos_cnt == 2) begin
      amask_seen = b;
      frame_len = int'(BASE_LENGTH) + $countones(b);
      fl_lo = fletcher_add(fl_lo, b);
      fl_hi = fletcher_add(fl_hi, fl_lo);
    end else if (pos_cnt + 3 < frame_len) begin
      k = nth_knob(amask_seen, pos_cnt - 3);
      if (k < KNOB_SLOTS && k < 4) knob_vals = knob_vals | (32'(b) << (8 * k));
      fl_lo = fletcher_add(fl_lo, b);
      fl_hi = fletcher_add(fl_hi, fl_lo);
    end else if (pos_cnt + 3 == frame_len) begin
      chk_hi_seen = b;
    end else if (pos_cnt + 2 == frame_len) begin
      chk_bad = (int'(chk_hi_seen) != fl_hi) || (int'(b) != fl_lo);
    end else begin
      decided = 1;
      if (chk_bad) code = ERR_CHECKSUM;
      else if (b != END_BYTE) code = ERR_BAD_END;
      else if (!buttons_ok(btn_seen)) code = ERR_BUTTONS;
      else if (!analog_ok(amask_seen)) code = ERR_ANALOG;
      else code = ERR_OK;
    end
    if (!decided && it.end_of_transfer) begin
      code = ERR_SHORT;
      decided = 1;
    end
    if (decided) begin
      res.ok = (code == ERR_OK);
      res.error_code = code;
      if (code == ERR_OK) begin
        res.buttons       = btn_seen;
        res.changed_mask  = amask_seen;
        res.analog_values = knob_vals;
      end
      done_flag = 1;
      got = 1;
    end
    if (pos_cnt < 15) pos_cnt++;
    if (it.end_of_transfer) clear_frame();
  endtask

  // one input transaction, with the sender's burst/gap pacing in front of it
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int        gap;
    bit        got;
    out_item_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (it.end_of_transfer) transfers_sent++;
    track_byte(it, got, res);
    if (typed) pending_verdicts.push_back(typed_res);
    else if (got) pending_verdicts.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // a trailing ignored byte may still be in flight
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apply_config(logic choice, logic assign_btn, logic [2:0] knobs,
                              logic [3:0] kbmask);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HAS_CHOICE;
    cfg_data  <= {3'($urandom_range(0, 7)), choice};
    @(posedge clk);
    p_choice  = choice;
    cfg_index <= CFG_HAS_ASSIGN;
    cfg_data  <= {3'($urandom_range(0, 7)), assign_btn};
    @(posedge clk);
    p_assign  = assign_btn;
    cfg_index <= CFG_KNOB_COUNT;
    cfg_data  <= {1'($urandom_range(0, 1)), knobs};
    @(posedge clk);
    p_knobs   = knobs;
    cfg_index <= CFG_KNOB_BUTTON;
    cfg_data  <= kbmask;
    @(posedge clk);
    p_kbmask  = kbmask;
    cfg_we    <= 1'b0;
    configs_used++;
  endtask

  // builds one SPI transfer into frame_q: mostly well-formed packets, some broken, some noise
  task automatic make_frame();
    int         kind, sub, n, cut, extra, lo, hi;
    logic [7:0] btn, am, b;
    logic [7:0] body[$];
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      n = $urandom_range(1, 16);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      b = 8'($urandom_range(0, 255));
      if (b == START_BYTE) b = b ^ 8'h80;
      body.push_back(b);
      n = $urandom_range(0, 4);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      btn = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) btn = btn & allowed_buttons();
      am = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) am = am & allowed_analog();
      lo = fletcher_add(0, btn);
      hi = lo;
      lo = fletcher_add(lo, am);
      hi = fletcher_add(hi, lo);
      body.push_back(START_BYTE);
      body.push_back(btn);
      body.push_back(am);
      repeat ($countones(am)) begin
        b = 8'($urandom_range(0, 255));
        body.push_back(b);
        lo = fletcher_add(lo, b);
        hi = fletcher_add(hi, lo);
      end
      body.push_back(8'(hi));
      body.push_back(8'(lo));
      body.push_back(END_BYTE);
      n = body.size();
      sub = $urandom_range(0, 99);
      if (sub < 10) begin
        body[n - 3 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end else if (sub < 18) begin
        body[n - 1] ^= 8'($urandom_range(1, 255));
      end else if (sub < 30) begin
        cut = $urandom_range(1, n - 1);
        while (body.size() > cut) void'(body.pop_back());
      end
      if (sub >= 30 && $urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, 3);
        repeat (extra) body.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (body[i]) frame_q.push_back({body[i], 1'(i == body.size() - 1)});
  endtask

  function automatic dir_row_t row(logic [7:0] b, logic last);
    dir_row_t r;
    r = '0;
    r.item.rx_byte = b;
    r.item.end_of_transfer = last;
    return r;
  endfunction

  function automatic dir_row_t row_verdict(logic [7:0] b, logic last, error_t code);
    dir_row_t r;
    r = row(b, last);
    r.typed = 1'b1;
    r.verdict.ok = (code == ERR_OK);
    r.verdict.error_code = code;
    return r;
  endfunction

  // output side: stall pattern, one long hold-off on request, verdict checking
  initial begin
    int        hold_left, seg_left, seg_mode, pat_idx;
    logic [7:0] pattern;
    logic      next_ready;
    out_item_t want;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    pat_idx   = 0;
    pattern   = 8'hFF;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report("verdict with nothing pending", 32'(out_data.error_code), 32'h0);
        end else begin
          want = pending_verdicts.pop_front();
          code_hits[want.error_code]++;
          if (out_data.ok !== want.ok) report("ok", 32'(out_data.ok), 32'(want.ok));
          if (out_data.error_code !== want.error_code)
            report("error_code", 32'(out_data.error_code), 32'(want.error_code));
          if (out_data.buttons !== want.buttons)
            report("buttons", 32'(out_data.buttons), 32'(want.buttons));
          if (out_data.changed_mask !== want.changed_mask)
            report("changed_mask", 32'(out_data.changed_mask), 32'(want.changed_mask));
          if (out_data.analog_values !== want.analog_values)
            report("analog_values", out_data.analog_values, want.analog_values);
        end
      end
      if (hold_pending) begin
        hold_pending = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
          pattern  = 8'($urandom_range(1, 255));
        end
        seg_left--;
        pat_idx = (pat_idx + 1) % 8;
        case (seg_mode)
          2: next_ready = 1'($urandom_range(0, 1));
          3: next_ready = pattern[pat_idx];
          default: next_ready = 1'b1;
        endcase
      end
      out_ready <= next_ready;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t  run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic       choice, assign_btn;
    logic [2:0] knobs;
    logic [3:0] kbmask;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_HAS_CHOICE;
    cfg_data  = '0;
    p_choice  = 1'b0;
    p_assign  = 1'b0;
    p_knobs   = '0;
    p_kbmask  = '0;
    foreach (code_hits[i]) code_hits[i] = 0;
    clear_frame();

    // reset configuration: no buttons, no knobs
    dir_rows = '{
      row_verdict(8'hFF, 1'b1, ERR_BAD_START),   // lone byte, not STX
      row_verdict(8'h00, 1'b0, ERR_BAD_START),
      row(8'hAA, 1'b1),                          // ignored after the verdict
      row_verdict(START_BYTE, 1'b1, ERR_SHORT),
      row(START_BYTE, 1'b0), row(8'h00, 1'b0), row(8'h00, 1'b0),
      row(8'h00, 1'b0), row(8'h00, 1'b0), row_verdict(END_BYTE, 1'b1, ERR_OK),
      row(START_BYTE, 1'b0), row(8'hFF, 1'b0), row(8'h00, 1'b0),
      row(8'hFF, 1'b0), row(8'hFF, 1'b0), row_verdict(END_BYTE, 1'b1, ERR_CHECKSUM),
      row(START_BYTE, 1'b0), row(8'h00, 1'b0), row(8'h00, 1'b0),
      row(8'h00, 1'b0), row(8'h00, 1'b0), row_verdict(8'hFF, 1'b1, ERR_BAD_END),
      row(START_BYTE, 1'b0), row(8'h01, 1'b0), row(8'h00, 1'b0),
      row(8'h02, 1'b0), row(8'h01, 1'b0), row_verdict(END_BYTE, 1'b1, ERR_BUTTONS)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].verdict);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin choice = 1; assign_btn = 1; knobs = 3'd4; kbmask = 4'hF; end
        1: begin choice = 0; assign_btn = 0; knobs = 3'd0; kbmask = 4'h0; end
        2: begin choice = 1; assign_btn = 1; knobs = 3'd7; kbmask = 4'hF; end
        default: begin
          choice     = 1'($urandom_range(0, 1));
          assign_btn = 1'($urandom_range(0, 1));
          knobs      = 3'($urandom_range(0, 7));
          kbmask     = 4'($urandom_range(0, 15));
        end
      endcase
      apply_config(choice, assign_btn, knobs, kbmask);
      steady = (ph % 3 == 0);
      // phase 3: output held off while bytes keep coming, so the input backs up
      if (ph == 3) hold_pending = 1;
      while (bytes_sent < ITEM_TARGET * (ph + 1) / NUM_PHASES) begin
        make_frame();
        foreach (frame_q[i]) send_item(frame_q[i], 1'b0, '0);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report("verdicts never delivered", 32'(pending_verdicts.size()), 32'h0);

    $display("Covered %0d bytes in %0d transfers over %0d register settings.",
             bytes_sent, transfers_sent, configs_used);
    $display("Verdicts: ok %0d, short %0d, bad start %0d, checksum %0d, bad end %0d, %s %0d, %s %0d",
             code_hits[ERR_OK], code_hits[ERR_SHORT], code_hits[ERR_BAD_START],
             code_hits[ERR_CHECKSUM], code_hits[ERR_BAD_END],
             "buttons", code_hits[ERR_BUTTONS], "analog", code_hits[ERR_ANALOG]);
    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
